[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define IBD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ibd assertion failed");

// condition in one cycle implies a condition in the next
`define IBD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("ibd assertion failed");

`else

`define IBD_ASSERT(label, prop)
`define IBD_ASSERT_NEXT(label, pre, post)

`endif

`endif

[rtl/ibd_pkg.sv]
package ibd_pkg;

  localparam int LINE_PIXELS_MAX  = 4096;
  localparam int SAMPLE_LINES_MAX = 63;
  localparam int INDEX_CAP        = 4096;

  localparam int BASE_CAP = (SAMPLE_LINES_MAX + 1) * LINE_PIXELS_MAX;
  localparam int N_MAX    = BASE_CAP + LINE_PIXELS_MAX;

  // counters
  localparam int BCNT_W = $clog2(BASE_CAP + 1);
  localparam int LCNT_W = $clog2(LINE_PIXELS_MAX + 1);
  localparam int N_W    = $clog2(N_MAX + 1);
  localparam int IDX_W  = $clog2(INDEX_CAP + 1);

  // channel sums and sums of squares
  localparam int LSUM_W = $clog2(64'd255 * 64'(LINE_PIXELS_MAX) + 64'd1);
  localparam int LSQ_W  = $clog2(64'd65025 * 64'(LINE_PIXELS_MAX) + 64'd1);
  localparam int S_W    = $clog2(64'd255 * 64'(N_MAX) + 64'd1);
  localparam int Q_W    = $clog2(64'd65025 * 64'(N_MAX) + 64'd1);

  // products
  localparam int LIM2_W = 16;
  localparam int NN_W   = 2 * N_W;
  localparam int PROD_W = (Q_W + N_W > 2 * S_W) ? Q_W + N_W : 2 * S_W;
  localparam int DN_W   = N_W + 8;
  localparam int NG_W   = N_W + 9;

  // shared multiplier: a full operand times b, one byte of b per cycle
  localparam int MA_W    = (NN_W > Q_W) ? NN_W : Q_W;
  localparam int MB_W    = (S_W > N_W) ? ((S_W > LIM2_W) ? S_W : LIM2_W)
                                       : ((N_W > LIM2_W) ? N_W : LIM2_W);
  localparam int DIGITS  = (MB_W + 7) / 8;
  localparam int MB_PAD  = DIGITS * 8;
  localparam int MACC_W  = MA_W + MB_PAD;
  localparam int DCNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // short queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIDE        = 3'd0,
    REG_SAMPLE      = 3'd1,
    REG_MAX_LINES   = 3'd2,
    REG_STDEV       = 3'd3,
    REG_COLOR_DIFF  = 3'd4,
    REG_GRAY_X2     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_BOTTOM = 2'd2,
    SIDE_LEFT   = 2'd3
  } side_e;

  typedef struct packed {
    side_e       side;
    logic [5:0]  sample_lines;
    logic [11:0] max_lines;
    logic [7:0]  stdev;
    logic [7:0]  color_diff;
    logic [8:0]  gray_x2;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    side:         SIDE_TOP,
    sample_lines: 6'd0,
    max_lines:    12'd1638,
    stdev:        8'd5,
    color_diff:   8'd10,
    gray_x2:      9'd255
  };

  // one finished candidate line, totals over baseline plus line
  typedef struct packed {
    logic                      exh;
    logic [IDX_W-1:0]          border;
    logic [N_W-1:0]            n;
    logic [2:0][S_W-1:0]       sum;
    logic [2:0][Q_W-1:0]       sq;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_START,
    BK_WAIT,
    BK_EVAL
  } back_state_e;

  typedef enum logic [3:0] {
    ST_NN  = 4'd0,
    ST_LNN = 4'd1,
    ST_NQ0 = 4'd2,
    ST_SS0 = 4'd3,
    ST_NQ1 = 4'd4,
    ST_SS1 = 4'd5,
    ST_NQ2 = 4'd6,
    ST_SS2 = 4'd7,
    ST_DN  = 4'd8,
    ST_NG  = 4'd9
  } step_e;

endpackage

[rtl/ibd_front.sv]
module ibd_front import ibd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic        end_of_line_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output entry_t      q_entry_o
);

  logic [2:0][S_W-1:0]    base_sum_q, base_sum_d, base_sum_eff;
  logic [2:0][Q_W-1:0]    base_sq_q, base_sq_d, base_sq_eff;
  logic [BCNT_W-1:0]      base_cnt_q, base_cnt_d, base_cnt_eff;
  logic [2:0][LSUM_W-1:0] line_sum_q, line_sum_d;
  logic [2:0][LSQ_W-1:0]  line_sq_q, line_sq_d;
  logic [LCNT_W-1:0]      line_cnt_q, line_cnt_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   in_cand_q, in_cand_d;

  logic [2:0][7:0]  pix;
  logic [2:0][15:0] pix_sq;
  logic             accept;
  logic             base_add;
  logic             line_add;
  logic             adj;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pix        = {blue_i, green_i, red_i};

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      pix_sq[c] = pix[c] * pix[c];
    end
  end

  // a sample pixel after candidates starts a new image
  assign base_cnt_eff = in_cand_q ? '0 : base_cnt_q;
  assign base_sum_eff = in_cand_q ? '0 : base_sum_q;
  assign base_sq_eff  = in_cand_q ? '0 : base_sq_q;
  assign base_add     = base_cnt_eff < BCNT_W'(BASE_CAP);
  assign line_add     = line_cnt_q < LCNT_W'(LINE_PIXELS_MAX);

  always_comb begin
    base_sum_d = base_sum_q;
    base_sq_d  = base_sq_q;
    base_cnt_d = base_cnt_q;
    line_sum_d = line_sum_q;
    line_sq_d  = line_sq_q;
    line_cnt_d = line_cnt_q;
    idx_d      = idx_q;
    in_cand_d  = in_cand_q;
    if (accept) begin
      if (!kind_i) begin
        base_sum_d = base_sum_eff;
        base_sq_d  = base_sq_eff;
        base_cnt_d = base_cnt_eff;
        if (base_add) begin
          for (int c = 0; c < 3; c++) begin
            base_sum_d[c] = base_sum_eff[c] + S_W'(pix[c]);
            base_sq_d[c]  = base_sq_eff[c] + Q_W'(pix_sq[c]);
          end
          base_cnt_d = base_cnt_eff + BCNT_W'(1);
        end
        if (in_cand_q) begin
          line_sum_d = '0;
          line_sq_d  = '0;
          line_cnt_d = '0;
          idx_d      = '0;
          in_cand_d  = 1'b0;
        end
      end else begin
        in_cand_d = 1'b1;
        if (end_of_line_i) begin
          line_sum_d = '0;
          line_sq_d  = '0;
          line_cnt_d = '0;
          if (idx_q < IDX_W'(INDEX_CAP)) begin
            idx_d = idx_q + IDX_W'(1);
          end
        end else if (line_add) begin
          for (int c = 0; c < 3; c++) begin
            line_sum_d[c] = line_sum_q[c] + LSUM_W'(pix[c]);
            line_sq_d[c]  = line_sq_q[c] + LSQ_W'(pix_sq[c]);
          end
          line_cnt_d = line_cnt_q + LCNT_W'(1);
        end
      end
    end
  end

  // totals for the line that ends with this pixel
  assign adj = (cfg_i.side == SIDE_RIGHT) || (cfg_i.side == SIDE_BOTTOM);

  always_comb begin
    q_entry_o.exh    = idx_q > IDX_W'(cfg_i.max_lines);
    q_entry_o.border = idx_q + IDX_W'(adj);
    q_entry_o.n      = N_W'(base_cnt_q) + N_W'(line_cnt_q) + N_W'(line_add);
    for (int c = 0; c < 3; c++) begin
      q_entry_o.sum[c] = base_sum_q[c] + S_W'(line_sum_q[c])
                       + (line_add ? S_W'(pix[c]) : '0);
      q_entry_o.sq[c]  = base_sq_q[c] + Q_W'(line_sq_q[c])
                       + (line_add ? Q_W'(pix_sq[c]) : '0);
    end
  end

  assign q_push_o = accept && kind_i && end_of_line_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_sum_q <= '0;
      base_sq_q  <= '0;
      base_cnt_q <= '0;
      line_sum_q <= '0;
      line_sq_q  <= '0;
      line_cnt_q <= '0;
      idx_q      <= '0;
      in_cand_q  <= 1'b0;
    end else begin
      base_sum_q <= base_sum_d;
      base_sq_q  <= base_sq_d;
      base_cnt_q <= base_cnt_d;
      line_sum_q <= line_sum_d;
      line_sq_q  <= line_sq_d;
      line_cnt_q <= line_cnt_d;
      idx_q      <= idx_d;
      in_cand_q  <= in_cand_d;
    end
  end

endmodule

[rtl/ibd_queue.sv]
module ibd_queue import ibd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   empty_o,
  output entry_t head_o
);

  entry_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/ibd_mul.sv]
module ibd_mul import ibd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MA_W-1:0]   a_i,
  input  logic [MB_W-1:0]   b_i,
  output logic              done_o,
  output logic [MACC_W-1:0] prod_o
);

  logic [MA_W-1:0]   a_q;
  logic [MB_PAD-1:0] b_q;
  logic [MACC_W-1:0] acc_q, acc_d;
  logic [MA_W+7:0]   part;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;

  // most significant byte of b first
  assign part  = a_q * b_q[MB_PAD-1 -: 8];
  assign acc_d = {acc_q[MACC_W-9:0], 8'h00} + MACC_W'(part);

  assign done_o = done_q;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= MB_PAD'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= {b_q[MB_PAD-9:0], 8'h00};
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == DCNT_W'(DIGITS - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DCNT_W'(1);
        if (cnt_q == DCNT_W'(DIGITS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

[rtl/ibd_back.sv]
module ibd_back import ibd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             q_empty_i,
  input  entry_t           head_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             found_o,
  output logic             exhausted_o,
  output logic [IDX_W-1:0] border_o
);

  back_state_e st_q, st_d;
  step_e       step_q, step_d;

  logic [NN_W-1:0]        nn_q;
  logic [PROD_W-1:0]      lnn_q;
  logic [2:0][PROD_W-1:0] nq_q, ss_q;
  logic [DN_W-1:0]        dn_q;
  logic [NG_W-1:0]        ng_q;

  logic              mul_start, mul_done;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [MACC_W-1:0] mul_prod;
  logic [LIM2_W-1:0] lim2;
  logic [1:0]        ch;

  logic              out_valid_q;
  logic              found_q, exh_q;
  logic [IDX_W-1:0]  border_q;
  logic              out_load;

  logic [2:0]        dev;
  logic [S_W-1:0]    smax, smin;
  logic [S_W+1:0]    sum3;
  logic [NG_W+1:0]   ng3;
  logic              spread, bright, found, need_out;

  assign lim2 = cfg_i.stdev * cfg_i.stdev;

  // channel of the current square or sum-of-squares product
  assign ch = 2'((step_q - ST_NQ0) >> 1);

  ibd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // border tests on the finished products
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dev[c] = (nq_q[c] > ss_q[c]) && ((nq_q[c] - ss_q[c]) > lnn_q);
    end
    smax = head_i.sum[0];
    smin = head_i.sum[0];
    for (int c = 1; c < 3; c++) begin
      if (head_i.sum[c] > smax) smax = head_i.sum[c];
      if (head_i.sum[c] < smin) smin = head_i.sum[c];
    end
    spread = PROD_W'(smax - smin) > PROD_W'(dn_q);
    sum3   = (S_W+2)'(head_i.sum[0]) + (S_W+2)'(head_i.sum[1])
           + (S_W+2)'(head_i.sum[2]);
    ng3    = (NG_W+2)'(ng_q) + {1'b0, ng_q, 1'b0};
    bright = PROD_W'({sum3, 1'b0}) > PROD_W'(ng3);
    found  = (|dev) || spread || bright;
  end

  assign need_out = head_i.exh || found;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: begin
        if (!q_empty_i) st_d = head_i.exh ? BK_EVAL : BK_START;
      end
      BK_START: st_d = BK_WAIT;
      BK_WAIT: begin
        if (mul_done) st_d = (step_q == ST_NG) ? BK_EVAL : BK_START;
      end
      BK_EVAL: begin
        if (q_pop_o) st_d = BK_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    q_pop_o   = 1'b0;
    out_load  = 1'b0;
    unique case (st_q)
      BK_IDLE: ;
      BK_START: begin
        mul_start = 1'b1;
        unique case (step_q)
          ST_NN: begin
            mul_a = MA_W'(head_i.n);
            mul_b = MB_W'(head_i.n);
          end
          ST_LNN: begin
            mul_a = MA_W'(nn_q);
            mul_b = MB_W'(lim2);
          end
          ST_NQ0, ST_NQ1, ST_NQ2: begin
            mul_a = MA_W'(head_i.sq[ch]);
            mul_b = MB_W'(head_i.n);
          end
          ST_SS0, ST_SS1, ST_SS2: begin
            mul_a = MA_W'(head_i.sum[ch]);
            mul_b = MB_W'(head_i.sum[ch]);
          end
          ST_DN: begin
            mul_a = MA_W'(head_i.n);
            mul_b = MB_W'(cfg_i.color_diff);
          end
          ST_NG: begin
            mul_a = MA_W'(head_i.n);
            mul_b = MB_W'(cfg_i.gray_x2);
          end
          default: ;
        endcase
      end
      BK_WAIT: ;
      BK_EVAL: begin
        if (!need_out || !out_valid_q || out_ready_i) begin
          q_pop_o  = 1'b1;
          out_load = need_out;
        end
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (st_q == BK_IDLE) begin
      step_d = ST_NN;
    end else if (st_q == BK_WAIT && mul_done && step_q != ST_NG) begin
      step_d = step_e'(step_q + 4'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_WAIT && mul_done) begin
      case (step_q)
        ST_NN:  nn_q     <= mul_prod[NN_W-1:0];
        ST_LNN: lnn_q    <= mul_prod[PROD_W-1:0];
        ST_NQ0: nq_q[0]  <= mul_prod[PROD_W-1:0];
        ST_SS0: ss_q[0]  <= mul_prod[PROD_W-1:0];
        ST_NQ1: nq_q[1]  <= mul_prod[PROD_W-1:0];
        ST_SS1: ss_q[1]  <= mul_prod[PROD_W-1:0];
        ST_NQ2: nq_q[2]  <= mul_prod[PROD_W-1:0];
        ST_SS2: ss_q[2]  <= mul_prod[PROD_W-1:0];
        ST_DN:  dn_q     <= mul_prod[DN_W-1:0];
        ST_NG:  ng_q     <= mul_prod[NG_W-1:0];
        default: ;
      endcase
    end
    if (out_load) begin
      found_q  <= !head_i.exh;
      exh_q    <= head_i.exh;
      border_q <= head_i.exh ? '0 : head_i.border;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_IDLE;
      step_q      <= ST_NN;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      step_q      <= step_d;
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign exhausted_o = exh_q;
  assign border_o    = border_q;

endmodule

[rtl/image_border_detector_unit.sv]
// image border detector: measures how deep a flat border runs in from one edge
//
// pixel channel (in_valid_i / in_ready_o): one rgb pixel per transaction,
// kind_i 0 for baseline sample pixels, 1 for candidate line pixels, with
// end_of_line_i on the last pixel of each candidate line
// result channel (out_valid_o / out_ready_i): at most one transaction per
// candidate line, carrying found_o, exhausted_o and border_o
// config channel (cfg_valid_i / cfg_ready_o): register index and data, always ready;
// to be written only while the block is idle, a user duty the block does not enforce
//
// pixels are taken one per cycle while the queue has room; a line end drops
// a snapshot of the totals into a two-entry queue, and the back end works it
// off with one shared multiplier that takes a byte of one operand per cycle:
// ten products per evaluated line, none for an exhausted one
// once both queue entries are taken, in_ready_o drops until one is retired
// a stalled result holds in the output register; the back end stops at the
// next result while it waits, and the front keeps filling the queue
// reset clears all sums, counters, the line index and the queue, and loads
// the register defaults
module image_border_detector_unit import ibd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic                  end_of_line_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic                  exhausted_o,
  output logic [IDX_W-1:0]      border_o
);

  cfg_t   cfg_q;
  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_entry, q_head;

  // configuration registers, indexes past the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SIDE:       cfg_q.side         <= side_e'(cfg_data_i[1:0]);
        REG_SAMPLE:     cfg_q.sample_lines <= cfg_data_i[5:0];
        REG_MAX_LINES:  cfg_q.max_lines    <= cfg_data_i[11:0];
        REG_STDEV:      cfg_q.stdev        <= cfg_data_i[7:0];
        REG_COLOR_DIFF: cfg_q.color_diff   <= cfg_data_i[7:0];
        REG_GRAY_X2:    cfg_q.gray_x2      <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // front: accumulate baseline and line statistics
  ibd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .end_of_line_i(end_of_line_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (q_entry)
  );

  // line snapshots waiting for evaluation
  ibd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .pop_i  (q_pop),
    .full_o (q_full),
    .empty_o(q_empty),
    .head_o (q_head)
  );

  // back: exact squared tests and result register
  ibd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .head_i     (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .found_o    (found_o),
    .exhausted_o(exhausted_o),
    .border_o   (border_o)
  );

`include "assert_macros.svh"

  // the front never pushes into a full queue, the back never pops an empty one
  `IBD_ASSERT(a_no_push_full, !(q_push && q_full))
  `IBD_ASSERT(a_no_pop_empty, !(q_pop && q_empty))
  // a result is either found or exhausted, and exhausted carries no depth
  `IBD_ASSERT(a_result_kind, !out_valid_o || (found_o != exhausted_o))
  `IBD_ASSERT(a_exh_border, !(out_valid_o && exhausted_o) || (border_o == '0))
  // a retired exhausted entry shows up at the output as an exhausted result next cycle
  `IBD_ASSERT_NEXT(a_pop_result, q_pop && q_head.exh, out_valid_o && exhausted_o)

endmodule
